FILE: design/pate_pkg.sv
// Shared types and codes for the packed array table engine.
`default_nettype none

package pate_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // Operation codes
   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_SEARCH = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] read_value;
      logic [INDEX_W-1:0]        found_position;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   // Broadcast from the control to every cell; flags are high only on an accepted transaction
   typedef struct packed {
      logic                      append;
      logic                      shift;
      logic                      read;
      logic                      search;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: design/pate_cell.sv
// One table position: holds an entry, shifts from its right neighbour, flags read and search hits.
`default_nettype none

module pate_cell import pate_pkg::*; #(
   parameter int POS = 0,
   parameter int CW  = 7
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cell_cmd_type              cmd,
   input  wire logic [CW-1:0]             count,
   input  wire logic signed [VALUE_W-1:0] next_entry,
   output logic signed [VALUE_W-1:0]      entry,
   output logic                           hit
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      hit_ff, hit_in;
   logic                      live;
   logic                      at_index;

   always_comb begin
      live     = int'(count) > POS;
      at_index = int'(cmd.index) == POS;

      entry_in = entry_ff;
      if (cmd.append && int'(count) == POS) begin
         entry_in = cmd.value;
      end else if (cmd.shift && int'(cmd.index) <= POS) begin
         // take the neighbour's entry to close the gap
         entry_in = next_entry;
      end

      hit_in = hit_ff;
      if (cmd.read) begin
         hit_in = at_index;
      end else if (cmd.search) begin
         hit_in = live && (entry_ff == cmd.value);
      end else if (cmd.append || cmd.shift) begin
         hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

`default_nettype wire

FILE: design/packed_array_table_engine.sv
// The response is registered: an accepted request moves to the evaluate state, which loads the
// response register once it is free. One transaction at a time, so no new request is taken
// until the response is loaded. The chain of cells shifts, writes and compares all positions
// in the accept cycle; the evaluate state then reduces the hit flags into the response register.
// Reset clears the live count, the control state, the hit flags and the response valid flag;
// the entries hold whatever they held and are never read before being written.
`default_nettype none

module packed_array_table_engine import pate_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EVAL = 1'b1;

   logic                      state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [1:0]                pend_kind_ff, pend_kind_in;
   logic [1:0]                pend_status_ff, pend_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      accept;
   logic                      full;
   logic                      index_ok;
   cell_cmd_type              cmd;
   logic signed [VALUE_W-1:0] cell_entry [DEPTH];
   logic [DEPTH-1:0]          cell_hit;

   logic                      any_hit;
   logic signed [VALUE_W-1:0] hit_value;
   int                        hit_pos;
   logic                      load_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = int'(count_ff) == DEPTH;
   assign index_ok  = int'(req_payload.index) < int'(count_ff);

   always_comb begin
      cmd.append = accept && (req_payload.kind == KIND_APPEND) && !full;
      cmd.shift  = accept && (req_payload.kind == KIND_REMOVE) && index_ok;
      cmd.read   = accept && (req_payload.kind == KIND_READ);
      cmd.search = accept && (req_payload.kind == KIND_SEARCH);
      cmd.value  = req_payload.value;
      cmd.index  = req_payload.index;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] next_entry;
      if (i == DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end
      pate_cell #(
         .POS (i),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .count      (count_ff),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .hit        (cell_hit[i])
      );
   end

   // Reduce the registered hit flags: first hit position and the hit entry
   always_comb begin
      any_hit   = 1'b0;
      hit_value = '0;
      hit_pos   = 0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_hit[i]) begin
            any_hit = 1'b1;
            hit_pos = i;
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_hit[i]) begin
            hit_value = hit_value | cell_entry[i];
         end
      end
   end

   assign load_rsp = (state_ff == S_EVAL) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      pend_kind_in   = pend_kind_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         state_in       = S_EVAL;
         pend_kind_in   = req_payload.kind;
         pend_status_in = ST_OK;
         case (req_payload.kind)
            KIND_APPEND: begin
               if (full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            KIND_REMOVE: begin
               if (!index_ok) begin
                  pend_status_in = ST_BAD_INDEX;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            KIND_READ: begin
               if (!index_ok) begin
                  pend_status_in = ST_BAD_INDEX;
               end
            end
            default: begin
               pend_status_in = ST_OK;
            end
         endcase
      end

      if (load_rsp) begin
         state_in                  = S_IDLE;
         rsp_valid_in              = 1'b1;
         rsp_in.status             = pend_status_ff;
         rsp_in.read_value         = '0;
         rsp_in.found_position     = '0;
         rsp_in.entry_count        = COUNT_W'(count_ff);
         if (pend_kind_ff == KIND_SEARCH) begin
            if (any_hit) begin
               rsp_in.found_position = INDEX_W'(hit_pos);
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end else if (pend_kind_ff == KIND_READ && pend_status_ff == ST_OK) begin
            rsp_in.read_value = hit_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         pend_kind_ff   <= KIND_APPEND;
         pend_status_ff <= ST_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         pend_kind_ff   <= pend_kind_in;
         pend_status_ff <= pend_status_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= DEPTH)
      else $error("live count beyond capacity");

   a_append_grows : assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.kind == KIND_APPEND && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the table");

   a_remove_shrinks : assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.kind == KIND_REMOVE && index_ok
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not shrink the table");

   a_eval_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EVAL && !req_ready)
      else $error("transaction not held for evaluation");

endmodule

`default_nettype wire
